@@ design/raster_neighbour_pair_generator_macros.svh @@
// assertion macros shared by the raster neighbour pair generator rtl
`ifndef RASTER_NEIGHBOUR_PAIR_GENERATOR_MACROS_SVH
`define RASTER_NEIGHBOUR_PAIR_GENERATOR_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define RNPG_ASSERT_IMPL(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("rnpg same-cycle check failed");

// next-cycle implication, quiet while reset is high
`define RNPG_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("rnpg next-cycle check failed");

`endif

@@ design/rnpg_pkg.sv @@
// shared constants for the raster neighbour pair generator
`default_nettype none
package rnpg_pkg;

   localparam int ID_BITS    = 32;
   localparam int DIR_BITS   = 3;
   localparam int NUM_DIRS   = 8;
   localparam int CSR_IDX_BITS = 2;

   // register indexes on the csr port
   localparam logic [CSR_IDX_BITS-1:0] REG_COLUMN_COUNT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_CELL_COUNT   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_EIGHT_WAY    = 2'd2;

   // direction codes, bit k of the masks below is direction k
   typedef enum logic [DIR_BITS-1:0] {
      DIR_TOPL  = 3'd0,
      DIR_TOP   = 3'd1,
      DIR_TOPR  = 3'd2,
      DIR_LEFT  = 3'd3,
      DIR_RIGHT = 3'd4,
      DIR_BOTL  = 3'd5,
      DIR_BOT   = 3'd6,
      DIR_BOTR  = 3'd7
   } dir_type;

   typedef logic [NUM_DIRS-1:0] dir_mask_type;

   localparam dir_mask_type FOUR_WAY_MASK = dir_mask_type'((1 << DIR_TOP) | (1 << DIR_LEFT)
                                           | (1 << DIR_RIGHT) | (1 << DIR_BOT));
   localparam dir_mask_type LEFT_MASK  = dir_mask_type'((1 << DIR_TOPL) | (1 << DIR_LEFT)
                                           | (1 << DIR_BOTL));
   localparam dir_mask_type RIGHT_MASK = dir_mask_type'((1 << DIR_TOPR) | (1 << DIR_RIGHT)
                                           | (1 << DIR_BOTR));
   localparam dir_mask_type UP_MASK    = dir_mask_type'((1 << DIR_TOPL) | (1 << DIR_TOP)
                                           | (1 << DIR_TOPR));
   localparam dir_mask_type DOWN_MASK  = dir_mask_type'((1 << DIR_BOTL) | (1 << DIR_BOT)
                                           | (1 << DIR_BOTR));

endpackage
`default_nettype wire

@@ design/rnpg_rem_pipe.sv @@
// pipelined restoring remainder unit, one quotient bit per stage
`default_nettype none
module rnpg_rem_pipe #(
   parameter int CELL_BITS = 24
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic                        in_valid,
   input  wire logic [CELL_BITS-1:0]        in_cell,
   input  wire logic [rnpg_pkg::ID_BITS-1:0] in_id,
   input  wire logic [CELL_BITS-1:0]        divisor,
   output logic                             out_valid,
   output logic [CELL_BITS-1:0]             out_cell,
   output logic [rnpg_pkg::ID_BITS-1:0]     out_id,
   output logic [CELL_BITS-1:0]             out_rem
);
   import rnpg_pkg::*;

   localparam int RW = CELL_BITS + 1;

   logic                 vld_ff  [CELL_BITS];
   logic [CELL_BITS-1:0] cell_ff [CELL_BITS];
   logic [ID_BITS-1:0]   id_ff   [CELL_BITS];
   logic [RW-1:0]        rem_ff  [CELL_BITS];
   logic [RW-1:0]        rem_in  [CELL_BITS];

   for (genvar k = 0; k < CELL_BITS; k++) begin : g_stage
      logic                 prev_vld;
      logic [CELL_BITS-1:0] prev_cell;
      logic [ID_BITS-1:0]   prev_id;
      logic [RW-1:0]        prev_rem;
      logic [RW-1:0]        trial;

      if (k == 0) begin : g_first
         assign prev_vld  = in_valid;
         assign prev_cell = in_cell;
         assign prev_id   = in_id;
         assign prev_rem  = '0;
      end else begin : g_rest
         assign prev_vld  = vld_ff[k-1];
         assign prev_cell = cell_ff[k-1];
         assign prev_id   = id_ff[k-1];
         assign prev_rem  = rem_ff[k-1];
      end

      // shift in the next dividend bit, subtract when it fits
      assign trial     = {prev_rem[RW-2:0], prev_cell[CELL_BITS-1-k]};
      assign rem_in[k] = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= prev_vld;
         end
         if (advance) begin
            cell_ff[k] <= prev_cell;
            id_ff[k]   <= prev_id;
            rem_ff[k]  <= rem_in[k];
         end
      end
   end

   assign out_valid = vld_ff[CELL_BITS-1];
   assign out_cell  = cell_ff[CELL_BITS-1];
   assign out_id    = id_ff[CELL_BITS-1];
   assign out_rem   = rem_ff[CELL_BITS-1][CELL_BITS-1:0];

endmodule
`default_nettype wire

@@ design/raster_neighbour_pair_generator.sv @@
// top level of the raster neighbour pair generator
// a request passes the remainder pipe, then the emitter, then the response registers;
// the emitter takes a new item only when at most one beat of the last is left to send,
// each item having up to 8 results; busy is high while the emitter has two or more beats left to send
// reset: synchronous, clears pipeline valids and the emitter, csr regs go to 1/1/1
`default_nettype none
`include "raster_neighbour_pair_generator_macros.svh"
module raster_neighbour_pair_generator #(
   parameter int CELL_BITS = 24
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // csr write port
   input  wire logic                            csr_write,
   input  wire logic [rnpg_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [CELL_BITS-1:0]            csr_wdata,
   // request channel
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [CELL_BITS-1:0]            req_source_cell,
   input  wire logic [rnpg_pkg::ID_BITS-1:0]    req_event_id,
   // response channel
   output logic                                 rsp_valid,
   output logic [CELL_BITS-1:0]                 rsp_from_cell,
   output logic [CELL_BITS-1:0]                 rsp_to_cell,
   output logic [rnpg_pkg::ID_BITS-1:0]         rsp_event_tag,
   output logic [rnpg_pkg::DIR_BITS-1:0]        rsp_direction,
   output logic                                 rsp_last
);
   import rnpg_pkg::*;

   // signed width for candidate indexes: cell +/- columns +/- 1 with no wrap
   localparam int W = CELL_BITS + 2;

   // csr registers
   logic [CELL_BITS-1:0] column_count_ff;
   logic [CELL_BITS-1:0] cell_count_ff;
   logic                 eight_way_ff;
   logic [CELL_BITS-1:0] cols_eff;

   // remainder pipe outputs
   logic                 rp_valid;
   logic [CELL_BITS-1:0] rp_cell;
   logic [ID_BITS-1:0]   rp_id;
   logic [CELL_BITS-1:0] rp_rem;

   // neighbour mask and targets formed from the pipe output
   dir_mask_type         keep_in;
   logic [CELL_BITS-1:0] to_in [NUM_DIRS];

   // emitter: holds one cell and sends one beat per pending direction
   dir_mask_type         em_mask_ff;
   logic [CELL_BITS-1:0] em_cell_ff;
   logic [ID_BITS-1:0]   em_id_ff;
   logic [CELL_BITS-1:0] em_to_ff [NUM_DIRS];
   logic [DIR_BITS-1:0]  pick;
   dir_mask_type         rest;
   logic                 advance;

   logic                 rsp_valid_ff;
   logic [CELL_BITS-1:0] rsp_from_ff;
   logic [CELL_BITS-1:0] rsp_to_ff;
   logic [ID_BITS-1:0]   rsp_tag_ff;
   logic [DIR_BITS-1:0]  rsp_dir_ff;
   logic                 rsp_last_ff;

   // csr writes; index 3 is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= CELL_BITS'(1);
         cell_count_ff   <= CELL_BITS'(1);
         eight_way_ff    <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_COLUMN_COUNT: column_count_ff <= csr_wdata;
            REG_CELL_COUNT:   cell_count_ff   <= csr_wdata;
            REG_EIGHT_WAY:    eight_way_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // zero columns behaves as one column
   assign cols_eff = (column_count_ff == '0) ? CELL_BITS'(1) : column_count_ff;

   // cell mod columns, one bit per stage; the whole pipe moves with advance
   rnpg_rem_pipe #(
      .CELL_BITS (CELL_BITS)
   ) u_rem_pipe (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (start && advance),
      .in_cell   (req_source_cell),
      .in_id     (req_event_id),
      .divisor   (cols_eff),
      .out_valid (rp_valid),
      .out_cell  (rp_cell),
      .out_id    (rp_id),
      .out_rem   (rp_rem)
   );

   // candidate index per direction, then edge wrap and range filtering
   always_comb begin
      logic signed [W-1:0] cell_s;
      logic signed [W-1:0] cols_s;
      logic signed [W-1:0] cand;
      logic                left_block;
      logic                right_block;
      cell_s      = $signed({2'b00, rp_cell});
      cols_s      = $signed({2'b00, cols_eff});
      left_block  = (rp_rem == CELL_BITS'(1));
      right_block = (rp_rem == '0);
      for (int k = 0; k < NUM_DIRS; k++) begin
         cand = cell_s;
         if (UP_MASK[k]) begin
            cand = cand - cols_s;
         end else if (DOWN_MASK[k]) begin
            cand = cand + cols_s;
         end
         if (LEFT_MASK[k]) begin
            cand = cand - W'(1);
         end else if (RIGHT_MASK[k]) begin
            cand = cand + W'(1);
         end
         keep_in[k] = rp_valid
                    && (eight_way_ff || FOUR_WAY_MASK[k])
                    && !(LEFT_MASK[k] && left_block)
                    && !(RIGHT_MASK[k] && right_block)
                    && (cand >= W'(1))
                    && (cand <= $signed({2'b00, cell_count_ff}));
         to_in[k] = cand[CELL_BITS-1:0];
      end
   end

   // lowest pending direction goes out first, which keeps the code order
   always_comb begin
      logic found;
      found = 1'b0;
      pick  = '0;
      for (int k = 0; k < NUM_DIRS; k++) begin
         if (em_mask_ff[k] && !found) begin
            pick  = DIR_BITS'(k);
            found = 1'b1;
         end
      end
      rest = em_mask_ff & ~(dir_mask_type'(1) << pick);
   end

   // the emitter frees up when at most one beat is left
   assign advance = (rest == '0);
   assign busy    = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         em_mask_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         em_mask_ff   <= advance ? keep_in : rest;
         rsp_valid_ff <= (em_mask_ff != '0);
      end
      if (advance) begin
         em_cell_ff <= rp_cell;
         em_id_ff   <= rp_id;
         for (int k = 0; k < NUM_DIRS; k++) begin
            em_to_ff[k] <= to_in[k];
         end
      end
      rsp_from_ff <= em_cell_ff;
      rsp_to_ff   <= em_to_ff[pick];
      rsp_tag_ff  <= em_id_ff;
      rsp_dir_ff  <= pick;
      rsp_last_ff <= (rest == '0);
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_from_cell = rsp_from_ff;
   assign rsp_to_cell   = rsp_to_ff;
   assign rsp_event_tag = rsp_tag_ff;
   assign rsp_direction = rsp_dir_ff;
   assign rsp_last      = rsp_last_ff;

   // beats of one cell come back to back until the last one
   `RNPG_ASSERT_NEXT(a_beats_contiguous, clock, reset, rsp_valid && !rsp_last, rsp_valid)
   // a stall only happens while beats are flowing
   `RNPG_ASSERT_NEXT(a_busy_emits, clock, reset, busy, rsp_valid)
   // a kept neighbour is never cell zero
   `RNPG_ASSERT_IMPL(a_to_nonzero, clock, reset, rsp_valid, rsp_to_cell != '0)

endmodule
`default_nettype wire
